[src/owtsm_pkg.sv]
`default_nettype none

package owtsm_pkg;

	localparam int SCRATCHPAD_BYTES = 9;
	localparam int TIMER_BITS       = 10;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int BYTE_CNT_W = 4;
	localparam int PHASE_W    = 4;

	typedef logic [TIMER_BITS-1:0] timer_t;
	typedef logic [BYTE_CNT_W-1:0] byte_cnt_t;

	// item kinds, also the code of the running operation
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;
	localparam logic [1:0] KIND_POLL  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_PRES  = 2'd1;
	localparam logic [1:0] ST_CRC_ERR  = 2'd2;
	localparam logic [1:0] ST_REFUSED  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_WAIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRES_STEP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRES_TRIES   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WZERO_LOW    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WONE_HIGH    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_READ_RECOVER = 3'd7;

	localparam logic [7:0] CMD_SKIP     = 8'hCC;
	localparam logic [7:0] CMD_CONVERT  = 8'h44;
	localparam logic [7:0] CMD_READ_PAD = 8'hBE;
	localparam logic [7:0] CRC_POLY     = 8'h8C;

	typedef struct packed {
		logic [9:0] reset_low_us;
		logic [7:0] release_wait_us;
		logic [7:0] presence_step_us;
		logic [3:0] presence_tries;
		logic [7:0] write_zero_low_us;
		logic [7:0] write_one_high_us;
		logic [5:0] read_sample_us;
		logic [7:0] read_recover_us;
	} cfg_t;

	typedef struct packed {
		logic              line_low;
		logic              busy;
		logic              done;
		logic [1:0]        status;
		logic signed [7:0] temperature;
		logic              ready;
	} res_t;

	// phase length for a delay register: max(d,1) ticks, so the timer loads d-1
	function automatic timer_t load_delay(input logic [15:0] d);
		logic [15:0] v;
		v = (d == 16'd0) ? 16'd0 : d - 16'd1;
		return timer_t'(v);
	endfunction

	// reflected CRC-8, polynomial 0x8C, one byte
	function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		logic [7:0] d;
		c = crc;
		d = b;
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ d[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
			d = d >> 1;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[src/owtsm_cfg.sv]
`default_nettype none

module owtsm_cfg import owtsm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	output      cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_us      <= 10'd460;
			cfg_q.release_wait_us   <= 8'd10;
			cfg_q.presence_step_us  <= 8'd15;
			cfg_q.presence_tries    <= 4'd10;
			cfg_q.write_zero_low_us <= 8'd50;
			cfg_q.write_one_high_us <= 8'd35;
			cfg_q.read_sample_us    <= 6'd4;
			cfg_q.read_recover_us   <= 8'd35;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RESET_LOW:    cfg_q.reset_low_us      <= wr_data[9:0];
				REG_RELEASE_WAIT: cfg_q.release_wait_us   <= wr_data[7:0];
				REG_PRES_STEP:    cfg_q.presence_step_us  <= wr_data[7:0];
				REG_PRES_TRIES:   cfg_q.presence_tries    <= wr_data[3:0];
				REG_WZERO_LOW:    cfg_q.write_zero_low_us <= wr_data[7:0];
				REG_WONE_HIGH:    cfg_q.write_one_high_us <= wr_data[7:0];
				REG_READ_SAMPLE:  cfg_q.read_sample_us    <= wr_data[5:0];
				REG_READ_RECOVER: cfg_q.read_recover_us   <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[src/owtsm_core.sv]
`default_nettype none

module owtsm_core import owtsm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [1:0] kind,
	input  wire logic       line_in,
	input  wire cfg_t       cfg,
	output      res_t       res
);

	localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
	localparam logic [PHASE_W-1:0] PH_RST_LOW   = 4'd1;
	localparam logic [PHASE_W-1:0] PH_RST_WAIT  = 4'd2;
	localparam logic [PHASE_W-1:0] PH_PRES_WAIT = 4'd3;
	localparam logic [PHASE_W-1:0] PH_REL_WAIT  = 4'd4;
	localparam logic [PHASE_W-1:0] PH_W_LOW     = 4'd5;
	localparam logic [PHASE_W-1:0] PH_W_HIGH    = 4'd6;
	localparam logic [PHASE_W-1:0] PH_R_LOW     = 4'd7;
	localparam logic [PHASE_W-1:0] PH_R_REL     = 4'd8;
	localparam logic [PHASE_W-1:0] PH_R_REC     = 4'd9;

	localparam byte_cnt_t LAST_BYTE = byte_cnt_t'(SCRATCHPAD_BYTES - 1);

	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [1:0]         op_q, op_d;
	timer_t             timer_q, timer_d;
	logic [3:0]         try_q, try_d;
	logic [2:0]         bit_q, bit_d;
	byte_cnt_t          byte_q, byte_d;
	logic [7:0]         shift_q, shift_d;
	logic [7:0]         crc_q, crc_d;
	logic [7:0]         raw_lo_q, raw_lo_d;
	logic [7:0]         raw_hi_q, raw_hi_d;
	logic               pend_q, pend_d;
	logic               done;
	logic [1:0]         status;
	logic [7:0]         temp;
	logic               ready;
	logic [15:0]        raw_word;
	logic [7:0]         temp_sum;

	always_comb begin
		phase_d  = phase_q;
		op_d     = op_q;
		timer_d  = timer_q;
		try_d    = try_q;
		bit_d    = bit_q;
		byte_d   = byte_q;
		shift_d  = shift_q;
		crc_d    = crc_q;
		raw_lo_d = raw_lo_q;
		raw_hi_d = raw_hi_q;
		pend_d   = pend_q;
		done     = 1'b0;
		status   = ST_OK;
		temp     = 8'd0;
		ready    = 1'b0;
		raw_word = 16'd0;
		temp_sum = 8'd0;

		if (phase_q == PH_IDLE) begin
			unique case (kind)
				KIND_START: begin
					if (pend_q) begin
						done   = 1'b1;
						status = ST_REFUSED;
					end else begin
						op_d    = KIND_START;
						phase_d = PH_RST_LOW;
						timer_d = load_delay(16'(cfg.reset_low_us));
					end
				end
				KIND_READ: begin
					pend_d  = 1'b0;
					op_d    = KIND_READ;
					phase_d = PH_RST_LOW;
					timer_d = load_delay(16'(cfg.reset_low_us));
				end
				KIND_POLL: begin
					if (pend_q) begin
						op_d    = KIND_POLL;
						shift_d = 8'd0;
						phase_d = PH_R_LOW;
						timer_d = '0;
					end else begin
						done   = 1'b1;
						status = ST_REFUSED;
					end
				end
				default: ;
			endcase
		end else if (phase_q == PH_REL_WAIT) begin
			// first high tick also opens the first write slot (SKIP ROM, bit 0 is zero)
			if (line_in) begin
				byte_d  = '0;
				bit_d   = '0;
				shift_d = CMD_SKIP;
				phase_d = PH_W_LOW;
				timer_d = load_delay(16'(cfg.write_zero_low_us));
			end
		end else if (timer_q != '0) begin
			timer_d = timer_q - timer_t'(1);
		end else begin
			unique case (phase_q)
				PH_RST_LOW: begin
					try_d   = '0;
					phase_d = PH_RST_WAIT;
					timer_d = load_delay(16'(cfg.release_wait_us));
				end
				PH_RST_WAIT: begin
					if (cfg.presence_tries == 4'd0) begin
						phase_d = PH_IDLE;
						timer_d = '0;
						done    = 1'b1;
						status  = ST_NO_PRES;
					end else begin
						phase_d = PH_PRES_WAIT;
						timer_d = load_delay(16'(cfg.presence_step_us));
					end
				end
				PH_PRES_WAIT: begin
					if (!line_in) begin
						phase_d = PH_REL_WAIT;
						timer_d = '0;
					end else begin
						try_d = try_q + 4'd1;
						if (try_d >= cfg.presence_tries) begin
							phase_d = PH_IDLE;
							timer_d = '0;
							done    = 1'b1;
							status  = ST_NO_PRES;
						end else begin
							phase_d = PH_PRES_WAIT;
							timer_d = load_delay(16'(cfg.presence_step_us));
						end
					end
				end
				PH_W_LOW: begin
					phase_d = PH_W_HIGH;
					timer_d = shift_q[0] ? timer_t'(cfg.write_one_high_us) : '0;
				end
				PH_W_HIGH: begin
					shift_d = shift_q >> 1;
					bit_d   = bit_q + 3'd1;
					if (bit_d != 3'd0) begin
						phase_d = PH_W_LOW;
						timer_d = shift_d[0] ? '0 : load_delay(16'(cfg.write_zero_low_us));
					end else if (byte_q == '0) begin
						byte_d  = byte_cnt_t'(1);
						shift_d = (op_q == KIND_START) ? CMD_CONVERT : CMD_READ_PAD;
						phase_d = PH_W_LOW;
						timer_d = shift_d[0] ? '0 : load_delay(16'(cfg.write_zero_low_us));
					end else if (op_q == KIND_START) begin
						pend_d  = 1'b1;
						phase_d = PH_IDLE;
						timer_d = '0;
						done    = 1'b1;
						status  = ST_OK;
					end else begin
						byte_d  = '0;
						crc_d   = 8'd0;
						shift_d = 8'd0;
						phase_d = PH_R_LOW;
						timer_d = '0;
					end
				end
				PH_R_LOW: begin
					phase_d = PH_R_REL;
					timer_d = load_delay(16'(cfg.read_sample_us));
				end
				PH_R_REL: begin
					shift_d = {line_in, shift_q[7:1]};
					phase_d = PH_R_REC;
					timer_d = load_delay(16'(cfg.read_recover_us));
				end
				PH_R_REC: begin
					if (op_q == KIND_POLL) begin
						ready   = shift_q[7];
						phase_d = PH_IDLE;
						timer_d = '0;
						done    = 1'b1;
						status  = ST_OK;
					end else begin
						bit_d = bit_q + 3'd1;
						if (bit_d != 3'd0) begin
							phase_d = PH_R_LOW;
							timer_d = '0;
						end else begin
							if (byte_q == byte_cnt_t'(0)) begin
								raw_lo_d = shift_q;
							end else if (byte_q == byte_cnt_t'(1)) begin
								raw_hi_d = shift_q;
							end
							if (byte_q == LAST_BYTE) begin
								phase_d = PH_IDLE;
								timer_d = '0;
								done    = 1'b1;
								if (crc_q == shift_q) begin
									raw_word = {raw_hi_d, raw_lo_d};
									temp_sum = raw_word[11:4] + {7'd0, raw_lo_d[3]};
									temp     = temp_sum;
									status   = ST_OK;
								end else begin
									status = ST_CRC_ERR;
								end
							end else begin
								crc_d   = crc_byte(crc_q, shift_q);
								byte_d  = byte_q + byte_cnt_t'(1);
								phase_d = PH_R_LOW;
								timer_d = '0;
							end
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
					timer_d = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			op_q     <= KIND_TICK;
			timer_q  <= '0;
			try_q    <= '0;
			bit_q    <= '0;
			byte_q   <= '0;
			shift_q  <= '0;
			crc_q    <= '0;
			raw_lo_q <= '0;
			raw_hi_q <= '0;
			pend_q   <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			op_q     <= op_d;
			timer_q  <= timer_d;
			try_q    <= try_d;
			bit_q    <= bit_d;
			byte_q   <= byte_d;
			shift_q  <= shift_d;
			crc_q    <= crc_d;
			raw_lo_q <= raw_lo_d;
			raw_hi_q <= raw_hi_d;
			pend_q   <= pend_d;
		end
	end

	assign res.line_low    = (phase_d == PH_RST_LOW) || (phase_d == PH_W_LOW) ||
	                         (phase_d == PH_R_LOW);
	assign res.busy        = (phase_d != PH_IDLE);
	assign res.done        = done;
	assign res.status      = status;
	assign res.temperature = temp;
	assign res.ready       = ready;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.done) |=> (phase_q == PH_IDLE))
		else $error("done without return to idle");

	a_low_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.line_low |-> res.busy)
		else $error("bus driven low while idle");

	a_pend_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pend_q) |-> ($past(op_q) == KIND_START && $past(phase_q) == PH_W_HIGH))
		else $error("conversion marked pending outside a start");

	a_busy_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q != PH_IDLE && kind != KIND_TICK) |-> (op_d == op_q))
		else $error("command taken while busy");

endmodule

`default_nettype wire

[src/onewire_temp_sensor_master.sv]
`default_nettype none

// 1-Wire bus master for a single temperature sensor. Each input item is one
// microsecond tick of bus time: it carries the sampled bus level (line_in) and
// an optional command (kind: tick only, start conversion, read temperature,
// poll ready). Each item gives exactly one result item with the bus drive for
// that tick (line_low), the busy flag, and on the tick a command ends done_res
// with status, temperature (read) or ready_res (poll). Commands given while
// busy are ignored. The block takes one item per clock cycle while the result
// register is free (a stalled output holds in_stall high); each item lands in
// the input register when accepted, and the single-pass step logic of the bus
// sequencer then loads the result register as the item moves on. Timing
// registers are written through the cfg port, which is always ready; write them
// only while no command is running.
module onewire_temp_sensor_master import owtsm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output      logic                  in_stall,
	input  wire logic [1:0]            kind,
	input  wire logic                  line_in,
	output      logic                  out_valid,
	input  wire logic                  out_stall,
	output      logic                  line_low,
	output      logic                  busy_res,
	output      logic                  done_res,
	output      logic [1:0]            status,
	output      logic signed [7:0]     temperature,
	output      logic                  ready_res,
	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t       cfg;
	res_t       res;
	res_t       res_q;
	logic       out_valid_q;
	logic       item_valid_s1;
	logic [1:0] kind_s1;
	logic       line_in_s1;
	logic       out_free;
	logic       advance;
	logic       in_take;

	// the result register is free when empty or being drained this cycle
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = item_valid_s1 && out_free;
	assign in_stall = item_valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	assign cfg_ready = 1'b1;

	owtsm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// step the sequencer once per tick item as it moves into the result register
	owtsm_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.kind    (kind_s1),
		.line_in (line_in_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// input register: hold the item until the sequencer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_take) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1    <= kind;
			line_in_s1 <= line_in;
		end
	end

	// result register: load on every sequencer step, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign line_low    = res_q.line_low;
	assign busy_res    = res_q.busy;
	assign done_res    = res_q.done;
	assign status      = res_q.status;
	assign temperature = res_q.temperature;
	assign ready_res   = res_q.ready;

endmodule

`default_nettype wire
